>>> src/bkdr_pkg.sv
`timescale 1ns / 1ps

package bkdr_pkg;

  localparam int unsigned HashW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutW     = 31;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CntW     = 5;

  localparam logic [HashW-1:0] HashSeed      = 32'd131;
  localparam logic [HashW-1:0] ModulusReset  = 32'd1;
  localparam logic [CntW-1:0]  LastBit       = CntW'(OutW - 1);

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_MODULUS = 1'b0
  } bkdr_reg_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } bkdr_div_state_e;

  // Queue status: full gates the input bytes, empty wakes the back
  typedef struct packed {
    logic empty;
    logic full;
  } bkdr_q_status_t;

endpackage

>>> src/bkdr_front.sv
`timescale 1ns / 1ps

module bkdr_front
  import bkdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [ByteW-1:0]    char_byte_i,
  output logic                enq_o,
  output logic [OutW-1:0]     enq_data_o
);

  logic [HashW-1:0] hash_q, hash_d;
  logic             term;

  assign term = (char_byte_i == '0);

  always_comb begin
    hash_d = hash_q;
    if (accept_i) begin
      if (term) begin
        hash_d = '0;
      end else begin
        hash_d = hash_q * HashSeed + HashW'(char_byte_i);
      end
    end
  end

  // The terminating byte hands the masked hash to the back
  assign enq_o      = accept_i && term;
  assign enq_data_o = hash_q[OutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  a_clear_on_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_o |=> (hash_q == '0))
    else $error("running hash not cleared after terminating byte");

endmodule

>>> src/bkdr_fifo.sv
`timescale 1ns / 1ps

module bkdr_fifo
  import bkdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                enq_i,
  input  logic [OutW-1:0]     enq_data_i,
  input  logic                deq_i,
  output logic [OutW-1:0]     deq_data_o,
  output bkdr_q_status_t      status_o
);

  logic [OutW-1:0] mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_enq, do_deq;

  assign status_o.empty = (cnt_q == 2'd0);
  assign status_o.full  = (cnt_q == 2'd2);
  assign do_enq = enq_i && !status_o.full;
  assign do_deq = deq_i && !status_o.empty;
  assign deq_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({do_enq, do_deq})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_enq) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_deq) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wr_ptr_q] <= enq_data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("queue count out of range");

  a_enq_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_enq |=> !status_o.empty)
    else $error("queue empty after a write");

endmodule

>>> src/bkdr_back.sv
`timescale 1ns / 1ps

module bkdr_back
  import bkdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  logic [OutW-1:0]     q_data_i,
  output logic                q_deq_o,
  input  logic [HashW-1:0]    modulus_i,
  output logic                empty,
  input  logic                pop,
  output logic [OutW-1:0]     bucket_hash_o
);

  bkdr_div_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q;
  logic [OutW-1:0]  dvd_q;
  logic [OutW-1:0]  rem_q;
  logic [HashW-1:0] div_q;
  logic [HashW-1:0] trial;
  logic             fits;
  logic             load;

  // One remainder bit per cycle; a zero divisor always "fits", so rem takes the dividend bits unchanged
  assign trial = {rem_q, dvd_q[OutW-1]};
  assign fits  = (trial >= div_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (!q_empty_i) begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt_q == '0) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (pop) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    empty   = 1'b1;
    unique case (state_q)
      DIV_IDLE: load  = !q_empty_i;
      DIV_RUN:  load  = 1'b0;
      DIV_DONE: empty = 1'b0;
      default: begin
        load  = 1'b0;
        empty = 1'b1;
      end
    endcase
  end

  assign q_deq_o       = load;
  assign bucket_hash_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q <= LastBit;
      end else if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dvd_q <= q_data_i;
      rem_q <= '0;
      div_q <= modulus_i;
    end else if (state_q == DIV_RUN) begin
      dvd_q <= {dvd_q[OutW-2:0], 1'b0};
      rem_q <= fits ? OutW'(trial - div_q) : trial[OutW-1:0];
    end
  end

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_DONE && div_q != '0) |-> (HashW'(rem_q) < div_q))
    else $error("remainder not below divisor");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_DONE && !pop) |=> (state_q == DIV_DONE && $stable(rem_q)))
    else $error("result lost before pop");

endmodule

>>> src/bkdr_string_hash_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     push / full               char_byte_i   [7:0]
// result    empty / pop               bucket_hash_o [30:0]
// config    APB psel/penable/pwrite   paddr [2:0], pwdata/prdata [31:0]; modulus at 0x0
//
// A byte is taken whenever full is low; the running hash updates in the front.
// A terminating byte queues the masked hash (two entries); the back reduces it
// with a restoring remainder unit, one bit per cycle, and takes the next hash
// only after its result is popped.
// full rises only while both queue entries are taken; a held result stalls the back.
// Reset: running hash 0, modulus 1, queue and back empty.

module bkdr_string_hash_unit
  import bkdr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [ByteW-1:0]   char_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [OutW-1:0]    bucket_hash_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  logic [HashW-1:0] modulus_q;
  logic             accept;
  logic             enq;
  logic [OutW-1:0]  enq_data;
  logic             deq;
  logic [OutW-1:0]  deq_data;
  bkdr_q_status_t   q_status;
  bkdr_reg_e        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = bkdr_reg_e'(paddr[2]);
  assign full    = q_status.full;
  assign accept  = push && !full;

  always_comb begin
    unique case (reg_sel)
      REG_MODULUS: prdata = modulus_q;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_MODULUS) begin
      modulus_q <= pwdata;
    end
  end

  bkdr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_byte_i (char_byte_i),
    .enq_o       (enq),
    .enq_data_o  (enq_data)
  );

  bkdr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (enq),
    .enq_data_i (enq_data),
    .deq_i      (deq),
    .deq_data_o (deq_data),
    .status_o   (q_status)
  );

  bkdr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_status.empty),
    .q_data_i      (deq_data),
    .q_deq_o       (deq),
    .modulus_i     (modulus_q),
    .empty         (empty),
    .pop           (pop),
    .bucket_hash_o (bucket_hash_o)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bkdr_pkg::*;

  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned PhaseItems = 135;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned DirRows = 30;
  localparam int unsigned IdlePct = 57;
  localparam int unsigned BothIdlePct = 22;

  localparam logic [HashW-1:0] BkdrMult = 32'd131;
  localparam logic [HashW-1:0] HashMask = 32'h7FFF_FFFF;
  localparam logic [ByteW-1:0] EndOfString = 8'h00;

  localparam logic [AddrW-1:0] AddrModulus = AddrW'({REG_MODULUS, 2'b00});
  localparam logic [AddrW-1:0] AddrSpare = 3'h4;   // index 1: no register there

  typedef enum logic {
    ROW_CHAR,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
    logic [ByteW-1:0] chr;
    logic             known;
    logic [OutW-1:0]  lit;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [ByteW-1:0]  char_byte_i;
  logic              empty;
  logic              pop;
  logic [OutW-1:0]   bucket_hash_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // predictor state
  logic [HashW-1:0]  acc_hash;
  logic [DataW-1:0]  cfg_modulus;
  logic [OutW-1:0]   bucket_fifo[$];

  int unsigned       fail_cnt;
  int unsigned       quiet_cycles;
  int unsigned       idle_pct;
  bit                send_lazy;
  bit                recv_lazy;
  bit                hold_req;
  dir_row_t          dir_tab[DirRows];

  bkdr_string_hash_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_byte_i   (char_byte_i),
    .empty         (empty),
    .pop           (pop),
    .bucket_hash_o (bucket_hash_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  // Fold one byte into the running hash; report a bucket on the terminator.
  function automatic bit fold_char(input logic [ByteW-1:0] chr, output logic [OutW-1:0] bucket);
    logic [HashW-1:0] masked;
    bucket = '0;
    if (chr != EndOfString) begin
      acc_hash = acc_hash * BkdrMult + HashW'(chr);
      return 1'b0;
    end
    masked = acc_hash & HashMask;
    // a zero divisor passes the masked hash through
    bucket = (cfg_modulus == '0) ? masked[OutW-1:0] : OutW'(masked % cfg_modulus);
    acc_hash = '0;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [ByteW-1:0] chr, input bit use_lit,
                           input logic [OutW-1:0] lit);
    logic [OutW-1:0] bucket;
    bit              emits;
    @(negedge clk_i);
    while (send_lazy && $urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    char_byte_i <= chr;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    emits = fold_char(chr, bucket);
    if (emits) bucket_fifo.push_back(use_lit ? lit : bucket);
  endtask

  // Hold the input, wait until every bucket is back and the divider is idle.
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (bucket_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    if (wr && (addr >> 2) == AddrW'(REG_MODULUS)) cfg_modulus = wdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_modulus(input logic [AddrW-1:0] addr, input logic [DataW-1:0] value);
    logic [DataW-1:0] rdata;
    settle();
    apb_access(1'b1, addr, value, rdata);
    apb_access(1'b0, AddrModulus, '0, rdata);
    if (rdata !== cfg_modulus) begin
      $error("modulus readback: expected %0h, got %0h", cfg_modulus, rdata);
      fail_cnt++;
    end
  endtask

  task automatic send_string(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_char(ByteW'($urandom_range(1, 255)), 1'b0, '0);
    end
    send_char(EndOfString, 1'b0, '0);
  endtask

  // result side
  initial begin
    int unsigned     hold_left;
    bit              want;
    logic [OutW-1:0] exp_bucket;
    hold_left = 0;
    pop       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        want = 1'b0;
      end else begin
        want = !(recv_lazy && $urandom_range(0, 99) < idle_pct);
      end
      pop <= want;
      @(posedge clk_i);
      if (pop && !empty) begin
        if (bucket_fifo.size() == 0) begin
          $error("bucket_hash: unexpected beat, got %0d", bucket_hash_o);
          fail_cnt++;
        end else begin
          exp_bucket = bucket_fifo.pop_front();
          if (bucket_hash_o !== exp_bucket) begin
            $error("bucket_hash: expected %0d, got %0d", exp_bucket, bucket_hash_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // watchdog: give up after a long stretch with no beat on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [DataW-1:0] phase_mod;
    int unsigned      sent;
    int unsigned      len;

    rst_ni       = 1'b0;
    push         = 1'b0;
    char_byte_i  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    fail_cnt     = 0;
    quiet_cycles = 0;
    idle_pct     = IdlePct;
    send_lazy    = 1'b0;
    recv_lazy    = 1'b0;
    hold_req     = 1'b0;
    acc_hash     = '0;
    cfg_modulus  = ModulusReset;

    dir_tab = '{
      '{ROW_CHAR, '0, '0, 8'h00, 1'b1, 31'd0},       // empty string
      '{ROW_CHAR, '0, '0, 8'h61, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h00, 1'b1, 31'd0},       // reset modulus of one
      '{ROW_CFG, AddrModulus, 32'h0, 8'h00, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'hFF, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h00, 1'b1, 31'd255},     // zero divisor passes through
      '{ROW_CHAR, '0, '0, 8'h01, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h80, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h00, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'hFF, 1'b0, '0},          // wrap the 32-bit hash
      '{ROW_CHAR, '0, '0, 8'hFF, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'hFF, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'hFF, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'hFF, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'hFF, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h00, 1'b0, '0},
      '{ROW_CFG, AddrModulus, 32'hFFFF_FFFF, 8'h00, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h7F, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'hFE, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h55, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h00, 1'b0, '0},
      '{ROW_CFG, AddrSpare, 32'h3, 8'h00, 1'b0, '0}, // unmapped: must be dropped
      '{ROW_CFG, AddrModulus, 32'h7, 8'h00, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h61, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h62, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h63, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h00, 1'b0, '0},
      '{ROW_CFG, AddrModulus, 32'h8000_0000, 8'h00, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'hAA, 1'b0, '0},
      '{ROW_CHAR, '0, '0, 8'h00, 1'b0, '0}
    };

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        set_modulus(dir_tab[i].addr, dir_tab[i].wdata);
      end else begin
        send_char(dir_tab[i].chr, dir_tab[i].known, dir_tab[i].lit);
      end
    end

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: phase_mod = DataW'($urandom_range(2, 5000));
        1: phase_mod = 32'hFFFF_FFFF;
        2: phase_mod = 32'h0;
        3: phase_mod = $urandom();
        4: phase_mod = ModulusReset;
        default: phase_mod = 32'h7FFF_FFFF;
      endcase
      set_modulus(AddrModulus, phase_mod);
      send_lazy = (ph % 4 == 1) || (ph % 4 == 3);
      recv_lazy = (ph % 4 == 2) || (ph % 4 == 3);
      // both sides idle less often when they idle together
      idle_pct  = (ph % 4 == 3) ? BothIdlePct : IdlePct;
      // stall the result side for a while so the queue fills and full rises
      if (ph == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
        send_string(len);
        sent += len + 1;
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (bucket_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
